// ===== src/dfla_pkg.sv =====
// dfla_pkg: widths, constants, arctangent table and pipeline sideband types
// for the launch angle solver; no dependencies
`default_nettype none

package dfla_pkg;

   localparam int IN_W      = 16;
   localparam int P_W       = 32;
   localparam int AN_W      = 53;
   localparam int X_W       = 53;
   localparam int Q_W       = 37;
   localparam int DISC_W    = 72;
   localparam int ROOT1_W   = DISC_W / 2;
   localparam int SUMSQ_W   = 108;
   localparam int ROOT2_W   = SUMSQ_W / 2;
   localparam int DIV_W     = 70;
   localparam int QUO_W     = 16;
   localparam int CX_W      = 56;
   localparam int Z_W       = 34;
   localparam int PITCH_W   = 16;
   localparam int TIME_W    = 16;
   localparam int NORM_BIT  = 50;
   localparam int ATAN_LEN  = 24;

   localparam logic [IN_W-1:0] GRAVITY_RESET = 16'd40072;
   localparam int PITCH_MAX = 25736;

   // atan(2^-i) in q2.30
   localparam int ATAN_Q30 [ATAN_LEN] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
   };

   typedef struct packed {
      logic            bad;
      logic            neg;
      logic [AN_W-1:0] an;
      logic [P_W-1:0]  p;
      logic [IN_W-1:0] d;
      logic [IN_W-1:0] v;
   } sq1_side_type;

   typedef struct packed {
      logic            bad;
      logic [X_W-1:0]  x;
      logic [AN_W-1:0] an;
      logic [X_W-1:0]  qv;
   } cor_side_type;

   typedef struct packed {
      logic                      bad;
      logic signed [PITCH_W-1:0] pitch;
      logic [X_W-1:0]            qv;
   } sq2_side_type;

   typedef struct packed {
      logic                      bad;
      logic                      sat;
      logic signed [PITCH_W-1:0] pitch;
      logic [X_W-1:0]            qv;
   } div_side_type;

endpackage

`default_nettype wire

// ===== src/dfla_sqrt.sv =====
// dfla_sqrt: pipelined floor square root, one result bit per stage,
// with a sideband bus carried alongside; no package dependency
`default_nettype none

module dfla_sqrt #(
   parameter int IN_W   = 72,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [IN_W-1:0]     in_radicand,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [IN_W/2-1:0]        out_root,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int RT_W = IN_W / 2;

   logic [IN_W-1:0]   rem_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic              vld_ff  [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];

   for (genvar s = 0; s < RT_W; s++) begin : g_stage
      localparam int K = RT_W - 1 - s;
      logic [IN_W-1:0]   rem_prev;
      logic [RT_W-1:0]   root_prev;
      logic              vld_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [IN_W+1:0]   trial;
      logic              take;
      logic [IN_W-1:0]   rem_in;
      logic [RT_W-1:0]   root_in;

      if (s == 0) begin : g_first
         assign rem_prev  = in_radicand;
         assign root_prev = '0;
         assign vld_prev  = in_valid;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign trial   = ((IN_W+2)'(root_prev) << (K + 1)) + ((IN_W+2)'(1) << (2 * K));
      assign take    = trial <= (IN_W+2)'(rem_prev);
      assign rem_in  = take ? rem_prev - trial[IN_W-1:0] : rem_prev;
      assign root_in = take ? root_prev | (RT_W'(1) << K) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

`default_nettype wire

// ===== src/dfla_cordic.sv =====
// dfla_cordic: normalization and pipelined cordic vectoring giving the
// rounded, clamped and signed pitch; depends on dfla_pkg
`default_nettype none

module dfla_cordic
   import dfla_pkg::*;
#(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [X_W-1:0]            in_x,
   input  wire logic [X_W-1:0]            in_y,
   input  wire logic                      in_neg,
   input  wire logic [SIDE_W-1:0]         in_side,
   output logic                           out_valid,
   output logic signed [PITCH_W-1:0]      out_pitch,
   output logic [SIDE_W-1:0]              out_side
);

   logic [X_W-1:0]    n1_x_in, n1_y_in, n2_x_in, n2_y_in;
   logic [X_W-1:0]    n1_x_ff, n1_y_ff, n2_x_ff, n2_y_ff;
   logic              n1_neg_ff, n2_neg_ff, n1_vld_ff, n2_vld_ff;
   logic [SIDE_W-1:0] n1_side_ff, n2_side_ff;

   // shift both left together until one reaches the limit
   always_comb begin
      n1_x_in = in_x;
      n1_y_in = in_y;
      for (int j = 0; j < 3; j++) begin
         if ((n1_x_in | n1_y_in) < (X_W'(1) << (NORM_BIT + 1 - (32 >> j)))) begin
            n1_x_in = n1_x_in << (32 >> j);
            n1_y_in = n1_y_in << (32 >> j);
         end
      end
   end

   always_comb begin
      n2_x_in = n1_x_ff;
      n2_y_in = n1_y_ff;
      for (int j = 0; j < 3; j++) begin
         if ((n2_x_in | n2_y_in) < (X_W'(1) << (NORM_BIT + 1 - (4 >> j)))) begin
            n2_x_in = n2_x_in << (4 >> j);
            n2_y_in = n2_y_in << (4 >> j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_vld_ff <= 1'b0;
         n2_vld_ff <= 1'b0;
      end else if (en) begin
         n1_vld_ff <= in_valid;
         n2_vld_ff <= n1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_x_ff    <= n1_x_in;
         n1_y_ff    <= n1_y_in;
         n1_neg_ff  <= in_neg;
         n1_side_ff <= in_side;
         n2_x_ff    <= n2_x_in;
         n2_y_ff    <= n2_y_in;
         n2_neg_ff  <= n1_neg_ff;
         n2_side_ff <= n1_side_ff;
      end
   end

   logic signed [CX_W-1:0] cx_ff   [STEPS];
   logic signed [CX_W-1:0] cy_ff   [STEPS];
   logic signed [Z_W-1:0]  z_ff    [STEPS];
   logic                   neg_ff  [STEPS];
   logic                   vld_ff  [STEPS];
   logic [SIDE_W-1:0]      side_ff [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic signed [CX_W-1:0] cx_prev, cy_prev, dx, dy;
      logic signed [Z_W-1:0]  z_prev;
      logic                   neg_prev, vld_prev;
      logic [SIDE_W-1:0]      side_prev;

      if (s == 0) begin : g_first
         assign cx_prev   = $signed(CX_W'(n2_x_ff));
         assign cy_prev   = $signed(CX_W'(n2_y_ff));
         assign z_prev    = '0;
         assign neg_prev  = n2_neg_ff;
         assign vld_prev  = n2_vld_ff;
         assign side_prev = n2_side_ff;
      end else begin : g_next
         assign cx_prev   = cx_ff[s-1];
         assign cy_prev   = cy_ff[s-1];
         assign z_prev    = z_ff[s-1];
         assign neg_prev  = neg_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign dx = cy_prev >>> s;
      assign dy = cx_prev >>> s;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!cy_prev[CX_W-1]) begin
               cx_ff[s] <= cx_prev + dx;
               cy_ff[s] <= cy_prev - dy;
               z_ff[s]  <= z_prev + Z_W'(ATAN_Q30[s]);
            end else begin
               cx_ff[s] <= cx_prev - dx;
               cy_ff[s] <= cy_prev + dy;
               z_ff[s]  <= z_prev - Z_W'(ATAN_Q30[s]);
            end
            neg_ff[s]  <= neg_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   logic signed [Z_W-1:0]     z_pos, z_rnd;
   logic [Z_W-17:0]           pq_raw;
   logic [PITCH_W-1:0]        pq_clip;
   logic signed [PITCH_W-1:0] pitch_in, pitch_ff;
   logic                      out_vld_ff;
   logic [SIDE_W-1:0]         out_side_ff;

   assign z_pos    = z_ff[STEPS-1][Z_W-1] ? '0 : z_ff[STEPS-1];
   assign z_rnd    = z_pos + Z_W'(32768);
   assign pq_raw   = z_rnd[Z_W-1:16];
   assign pq_clip  = (pq_raw > (Z_W-16)'(PITCH_MAX)) ? PITCH_W'(PITCH_MAX)
                                                      : pq_raw[PITCH_W-1:0];
   assign pitch_in = neg_ff[STEPS-1] ? -$signed(pq_clip) : $signed(pq_clip);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pitch_ff    <= pitch_in;
         out_side_ff <= side_ff[STEPS-1];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_pitch = pitch_ff;
   assign out_side  = out_side_ff;

endmodule

`default_nettype wire

// ===== src/drag_free_launch_angle_solver.sv =====
// drag_free_launch_angle_solver: top level of the drag-free launch angle solver
// depends on dfla_pkg, dfla_sqrt and dfla_cordic
//
// usage:
//   req channel (valid/stall) carries muzzle speed, horizontal distance and
//   target height; a transfer happens when req_valid is high and req_stall low.
//   rsp channel (valid/stall) returns pitch, flight time and the no-solution
//   flag, one result per request, in order.
//   csr channel (valid/ready, always ready) writes gravity; write only while idle.
//   pipeline depth is set by the two bit-per-stage square roots, the cordic
//   steps and the 16-stage divider.
//   throughput is one request per cycle while req_stall is low.
//   reset clears all valid bits and loads the default gravity.
//   when the receiver stalls a waiting result, the pipeline still moves while
//   its last stage is empty; once a result waits behind it, req_stall rises and
//   every stage holds.
`default_nettype none

module drag_free_launch_angle_solver
   import dfla_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [IN_W-1:0]             req_muzzle_speed,
   input  wire logic [IN_W-1:0]             req_horiz_distance,
   input  wire logic signed [IN_W-1:0]      req_target_height,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [PITCH_W-1:0]        rsp_pitch_angle,
   output logic [TIME_W-1:0]                rsp_flight_time,
   output logic                             rsp_no_solution,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [IN_W-1:0]             csr_gravity_accel
);

   logic            en, last_vld, out_load;
   logic [IN_W-1:0] gravity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAVITY_RESET;
      end else if (csr_valid) begin
         gravity_ff <= csr_gravity_accel;
      end
   end

   // front end: products, n, |n|, g*|n|, discriminant
   logic                   s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic                   s5_vld_ff, s6_vld_ff, s7_vld_ff;
   logic [IN_W-1:0]        s1_v_ff, s1_d_ff, s1_g_ff;
   logic signed [IN_W-1:0] s1_h_ff;
   logic [P_W-1:0]         s1_p_ff, s1_gd_ff;
   logic                   s1_zero_ff;
   logic [47:0]            s2_gdd_ff;
   logic signed [48:0]     s2_hp_ff;
   logic [63:0]            s2_pp_ff;
   logic [P_W-1:0]         s2_p_ff;
   logic [IN_W-1:0]        s2_v_ff, s2_d_ff, s2_g_ff;
   logic                   s2_zero_ff;
   logic signed [53:0]     s3_n_ff;
   logic [69:0]            s3_a_ff;
   logic [P_W-1:0]         s3_p_ff;
   logic [IN_W-1:0]        s3_v_ff, s3_d_ff, s3_g_ff;
   logic                   s3_zero_ff;
   logic [AN_W-1:0]        s4_an_ff;
   logic                   s4_neg_ff;
   logic [69:0]            s4_a_ff;
   logic [P_W-1:0]         s4_p_ff;
   logic [IN_W-1:0]        s4_v_ff, s4_d_ff, s4_g_ff;
   logic                   s4_zero_ff;
   logic [42:0]            s5_blo_ff;
   logic [41:0]            s5_bhi_ff;
   logic [AN_W-1:0]        s5_an_ff;
   logic                   s5_neg_ff;
   logic [69:0]            s5_a_ff;
   logic [P_W-1:0]         s5_p_ff;
   logic [IN_W-1:0]        s5_v_ff, s5_d_ff;
   logic                   s5_zero_ff;
   logic [68:0]            s6_b_ff;
   logic [AN_W-1:0]        s6_an_ff;
   logic                   s6_neg_ff;
   logic [69:0]            s6_a_ff;
   logic [P_W-1:0]         s6_p_ff;
   logic [IN_W-1:0]        s6_v_ff, s6_d_ff;
   logic                   s6_zero_ff;
   logic [DISC_W-1:0]      s7_disc_ff;
   sq1_side_type           s7_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_v_ff    <= req_muzzle_speed;
         s1_d_ff    <= req_horiz_distance;
         s1_h_ff    <= req_target_height;
         s1_g_ff    <= gravity_ff;
         s1_p_ff    <= req_muzzle_speed * req_muzzle_speed;
         s1_gd_ff   <= gravity_ff * req_horiz_distance;
         s1_zero_ff <= (req_muzzle_speed == '0) || (req_horiz_distance == '0);

         s2_gdd_ff  <= s1_gd_ff * s1_d_ff;
         s2_hp_ff   <= s1_h_ff * $signed({1'b0, s1_p_ff});
         s2_pp_ff   <= s1_p_ff * s1_p_ff;
         s2_p_ff    <= s1_p_ff;
         s2_v_ff    <= s1_v_ff;
         s2_d_ff    <= s1_d_ff;
         s2_g_ff    <= s1_g_ff;
         s2_zero_ff <= s1_zero_ff;

         s3_n_ff    <= $signed({6'd0, s2_gdd_ff}) + ($signed(54'(s2_hp_ff)) <<< 4);
         s3_a_ff    <= {s2_pp_ff, 6'd0};
         s3_p_ff    <= s2_p_ff;
         s3_v_ff    <= s2_v_ff;
         s3_d_ff    <= s2_d_ff;
         s3_g_ff    <= s2_g_ff;
         s3_zero_ff <= s2_zero_ff;

         s4_an_ff   <= s3_n_ff[53] ? AN_W'(-s3_n_ff) : AN_W'(s3_n_ff);
         s4_neg_ff  <= s3_n_ff[53];
         s4_a_ff    <= s3_a_ff;
         s4_p_ff    <= s3_p_ff;
         s4_v_ff    <= s3_v_ff;
         s4_d_ff    <= s3_d_ff;
         s4_g_ff    <= s3_g_ff;
         s4_zero_ff <= s3_zero_ff;

         s5_blo_ff  <= s4_g_ff * s4_an_ff[26:0];
         s5_bhi_ff  <= s4_g_ff * s4_an_ff[AN_W-1:27];
         s5_an_ff   <= s4_an_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_a_ff    <= s4_a_ff;
         s5_p_ff    <= s4_p_ff;
         s5_v_ff    <= s4_v_ff;
         s5_d_ff    <= s4_d_ff;
         s5_zero_ff <= s4_zero_ff;

         s6_b_ff    <= {s5_bhi_ff, 27'd0} + 69'(s5_blo_ff);
         s6_an_ff   <= s5_an_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_a_ff    <= s5_a_ff;
         s6_p_ff    <= s5_p_ff;
         s6_v_ff    <= s5_v_ff;
         s6_d_ff    <= s5_d_ff;
         s6_zero_ff <= s5_zero_ff;

         s7_disc_ff     <= s6_neg_ff ? DISC_W'(s6_a_ff) + DISC_W'(s6_b_ff)
                                     : DISC_W'(s6_a_ff) - DISC_W'(s6_b_ff);
         s7_side_ff.bad <= s6_zero_ff || (!s6_neg_ff && (70'(s6_b_ff) > s6_a_ff));
         s7_side_ff.neg <= s6_neg_ff;
         s7_side_ff.an  <= s6_an_ff;
         s7_side_ff.p   <= s6_p_ff;
         s7_side_ff.d   <= s6_d_ff;
         s7_side_ff.v   <= s6_v_ff;
      end
   end

   logic                 sq1_vld;
   logic [ROOT1_W-1:0]   sq1_root;
   logic [$bits(sq1_side_type)-1:0] sq1_side_raw;
   sq1_side_type         sq1_side;

   dfla_sqrt #(
      .IN_W   (DISC_W),
      .SIDE_W ($bits(sq1_side_type))
   ) u_disc_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s7_vld_ff),
      .in_radicand (s7_disc_ff),
      .in_side     (s7_side_ff),
      .out_valid   (sq1_vld),
      .out_root    (sq1_root),
      .out_side    (sq1_side_raw)
   );

   assign sq1_side = sq1_side_raw;

   // q = 8p + sqrt(disc), x = d*q, qv = q*v
   logic              t1_vld_ff, t2_vld_ff, t3_vld_ff;
   logic [Q_W-1:0]    t1_q_ff;
   sq1_side_type      t1_side_ff, t2_side_ff;
   logic [34:0]       t2_xl_ff, t2_vl_ff;
   logic [33:0]       t2_xh_ff, t2_vh_ff;
   logic [X_W-1:0]    t3_x_ff;
   logic              t3_neg_ff;
   cor_side_type      t3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
         t2_vld_ff <= 1'b0;
         t3_vld_ff <= 1'b0;
      end else if (en) begin
         t1_vld_ff <= sq1_vld;
         t2_vld_ff <= t1_vld_ff;
         t3_vld_ff <= t2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_q_ff    <= Q_W'({sq1_side.p, 3'd0}) + Q_W'(sq1_root);
         t1_side_ff <= sq1_side;

         t2_xl_ff   <= t1_side_ff.d * t1_q_ff[18:0];
         t2_xh_ff   <= t1_side_ff.d * t1_q_ff[Q_W-1:19];
         t2_vl_ff   <= t1_side_ff.v * t1_q_ff[18:0];
         t2_vh_ff   <= t1_side_ff.v * t1_q_ff[Q_W-1:19];
         t2_side_ff <= t1_side_ff;

         t3_x_ff        <= X_W'({t2_xh_ff, 19'd0}) + X_W'(t2_xl_ff);
         t3_neg_ff      <= t2_side_ff.neg;
         t3_side_ff.bad <= t2_side_ff.bad;
         t3_side_ff.x   <= X_W'({t2_xh_ff, 19'd0}) + X_W'(t2_xl_ff);
         t3_side_ff.an  <= t2_side_ff.an;
         t3_side_ff.qv  <= X_W'({t2_vh_ff, 19'd0}) + X_W'(t2_vl_ff);
      end
   end

   logic                      cor_vld;
   logic signed [PITCH_W-1:0] cor_pitch;
   logic [$bits(cor_side_type)-1:0] cor_side_raw;
   cor_side_type              cor_side;

   dfla_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W ($bits(cor_side_type))
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t3_vld_ff),
      .in_x      (t3_x_ff),
      .in_y      (t3_side_ff.an),
      .in_neg    (t3_neg_ff),
      .in_side   (t3_side_ff),
      .out_valid (cor_vld),
      .out_pitch (cor_pitch),
      .out_side  (cor_side_raw)
   );

   assign cor_side = cor_side_raw;

   // x*x + y*y from 27-bit partial products
   logic               u1_vld_ff, u2_vld_ff;
   logic [51:0]        u1_xhh_ff, u1_yhh_ff;
   logic [52:0]        u1_xhl_ff, u1_yhl_ff;
   logic [53:0]        u1_xll_ff, u1_yll_ff;
   sq2_side_type       u1_side_ff, u2_side_ff;
   logic [SUMSQ_W-1:0] u2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_vld_ff <= 1'b0;
         u2_vld_ff <= 1'b0;
      end else if (en) begin
         u1_vld_ff <= cor_vld;
         u2_vld_ff <= u1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_xhh_ff        <= cor_side.x[X_W-1:27] * cor_side.x[X_W-1:27];
         u1_xhl_ff        <= cor_side.x[X_W-1:27] * cor_side.x[26:0];
         u1_xll_ff        <= cor_side.x[26:0] * cor_side.x[26:0];
         u1_yhh_ff        <= cor_side.an[AN_W-1:27] * cor_side.an[AN_W-1:27];
         u1_yhl_ff        <= cor_side.an[AN_W-1:27] * cor_side.an[26:0];
         u1_yll_ff        <= cor_side.an[26:0] * cor_side.an[26:0];
         u1_side_ff.bad   <= cor_side.bad;
         u1_side_ff.pitch <= cor_pitch;
         u1_side_ff.qv    <= cor_side.qv;

         u2_sum_ff  <= SUMSQ_W'({u1_xhh_ff, 54'd0}) + SUMSQ_W'({u1_xhl_ff, 28'd0})
                     + SUMSQ_W'(u1_xll_ff) + SUMSQ_W'({u1_yhh_ff, 54'd0})
                     + SUMSQ_W'({u1_yhl_ff, 28'd0}) + SUMSQ_W'(u1_yll_ff);
         u2_side_ff <= u1_side_ff;
      end
   end

   logic               sq2_vld;
   logic [ROOT2_W-1:0] sq2_root;
   logic [$bits(sq2_side_type)-1:0] sq2_side_raw;
   sq2_side_type       sq2_side;

   dfla_sqrt #(
      .IN_W   (SUMSQ_W),
      .SIDE_W ($bits(sq2_side_type))
   ) u_range_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (u2_vld_ff),
      .in_radicand (u2_sum_ff),
      .in_side     (u2_side_ff),
      .out_valid   (sq2_vld),
      .out_root    (sq2_root),
      .out_side    (sq2_side_raw)
   );

   assign sq2_side = sq2_side_raw;

   // flight time = floor((2048r + floor(qv/2)) / qv), saturating
   logic             d1_vld_ff, d2_vld_ff;
   logic [DIV_W-1:0] d1_num_ff, d2_num_ff;
   sq2_side_type     d1_side_ff;
   div_side_type     d2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
      end else if (en) begin
         d1_vld_ff <= sq2_vld;
         d2_vld_ff <= d1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_num_ff  <= DIV_W'({sq2_root, 11'd0}) + DIV_W'(sq2_side.qv[X_W-1:1]);
         d1_side_ff <= sq2_side;

         d2_num_ff        <= d1_num_ff;
         d2_side_ff.bad   <= d1_side_ff.bad;
         d2_side_ff.sat   <= d1_num_ff >= DIV_W'({d1_side_ff.qv, 16'd0});
         d2_side_ff.pitch <= d1_side_ff.pitch;
         d2_side_ff.qv    <= d1_side_ff.qv;
      end
   end

   logic [DIV_W-1:0] div_rem_ff  [QUO_W];
   logic [QUO_W-1:0] div_q_ff    [QUO_W];
   logic             div_vld_ff  [QUO_W];
   div_side_type     div_side_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_div
      localparam int K = QUO_W - 1 - s;
      logic [DIV_W-1:0] rem_prev, den_sh;
      logic [QUO_W-1:0] q_prev;
      logic             vld_prev, take;
      div_side_type     side_prev;

      if (s == 0) begin : g_first
         assign rem_prev  = d2_num_ff;
         assign q_prev    = '0;
         assign vld_prev  = d2_vld_ff;
         assign side_prev = d2_side_ff;
      end else begin : g_next
         assign rem_prev  = div_rem_ff[s-1];
         assign q_prev    = div_q_ff[s-1];
         assign vld_prev  = div_vld_ff[s-1];
         assign side_prev = div_side_ff[s-1];
      end

      assign den_sh = DIV_W'(side_prev.qv) << K;
      assign take   = rem_prev >= den_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[s] <= 1'b0;
         end else if (en) begin
            div_vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_rem_ff[s]  <= take ? rem_prev - den_sh : rem_prev;
            div_q_ff[s]    <= take ? q_prev | (QUO_W'(1) << K) : q_prev;
            div_side_ff[s] <= side_prev;
         end
      end
   end

   // output register
   logic                      rsp_valid_ff, rsp_no_solution_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic [TIME_W-1:0]         rsp_time_ff;
   div_side_type              last_side;

   assign last_vld  = div_vld_ff[QUO_W-1];
   assign last_side = div_side_ff[QUO_W-1];
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign en        = out_load || !last_vld;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= last_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_no_solution_ff <= last_side.bad;
         rsp_pitch_ff       <= last_side.bad ? '0 : last_side.pitch;
         rsp_time_ff        <= last_side.bad ? '0
                             : (last_side.sat ? '1 : div_q_ff[QUO_W-1]);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_flight_time = rsp_time_ff;
   assign rsp_no_solution = rsp_no_solution_ff;

`ifndef SYNTHESIS
   a_no_solution_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_solution |-> rsp_pitch_angle == '0 && rsp_flight_time == '0)
      else $error("no-solution result carries nonzero fields");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= PITCH_W'(PITCH_MAX)
                    && rsp_pitch_angle >= -$signed(PITCH_W'(PITCH_MAX)))
      else $error("pitch out of range");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && last_vld)
      else $error("request stalled without a blocked result");
`endif

endmodule

`default_nettype wire
